// ----- rtl/dts_pkg.sv -----
// ----------------------------------------------------------------------------
// Digit transition sequencer package
// Shared widths, codes, state type and digit-to-channel mapping.
// ----------------------------------------------------------------------------
package dts_pkg;

  // Field and datapath widths.
  localparam int NUM_DIGITS = 10;
  localparam int DUTY_BITS  = 12;
  localparam int CH_W       = 4;
  localparam int DIGIT_W    = 4;
  localparam int STEP_W     = 16;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int PROD_W     = DUTY_BITS + STEP_W;
  localparam int CNT_W      = $clog2(DUTY_BITS);
  localparam int RES_W      = 2;
  localparam int MAX_RES    = 3;

  // Channel wiring: digit d sits on channel PIN_BASE - d, except digits 0 and 1.
  localparam logic [CH_W-1:0] PIN_BASE   = CH_W'(11);
  localparam logic [CH_W-1:0] CH_DIGIT_0 = CH_W'(1);
  localparam logic [CH_W-1:0] CH_DIGIT_1 = CH_W'(0);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHT = CFG_IDX_W'(1);

  // Command codes.
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_SET  = 1'b1;

  // Transition modes; the spare code behaves as a plain switch.
  typedef enum logic [MODE_W-1:0] {
    MODE_NORMAL  = 2'd0,
    MODE_FADE    = 2'd1,
    MODE_SHUFFLE = 2'd2,
    MODE_SPARE   = 2'd3
  } mode_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_EMIT
  } state_t;

  // Map a digit to its PWM channel. Codes above nine wrap modulo ten.
  function automatic logic [CH_W-1:0] digit_to_channel(input logic [DIGIT_W-1:0] d);
    logic [DIGIT_W-1:0] r;
    r = (d >= DIGIT_W'(NUM_DIGITS)) ? d - DIGIT_W'(NUM_DIGITS) : d;
    case (r)
      DIGIT_W'(0): digit_to_channel = CH_DIGIT_0;
      DIGIT_W'(1): digit_to_channel = CH_DIGIT_1;
      default:     digit_to_channel = PIN_BASE - CH_W'(r);
    endcase
  endfunction

endpackage

// ----- rtl/digit_transition_sequencer.sv -----
// ----------------------------------------------------------------------------
// Digit transition sequencer
// Turns set and tick commands into channel/duty writes for a ten-channel
// PWM display, with plain, cross-fade and shuffle transitions.
// ----------------------------------------------------------------------------
// A set beat gives no results. A tick beat in plain or shuffle mode places
// its two or three results into the output register at one per cycle while
// the output side does not stall. A fading tick first runs a shift-and-add
// multiplier and a restoring divider, each one bit per cycle over the twelve
// duty bits. The block takes a new input beat as soon as the last result of
// the previous one sits in the output register; after a tick that gives no
// results it stays ready for the next beat.
module digit_transition_sequencer
  import dts_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // Configuration writes
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DUTY_BITS-1:0] cfg_data,
  // Command input
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 cmd,
  input  logic [DIGIT_W-1:0]   digit,
  input  logic [STEP_W-1:0]    steps,
  // Channel write output
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [CH_W-1:0]      channel,
  output logic [DUTY_BITS-1:0] duty,
  output logic                 last
);

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DUTY_BITS - 1);

  // Configuration registers
  mode_t                mode;
  logic [DUTY_BITS-1:0] bright;

  // Transition state
  logic [CH_W-1:0]      cur_ch;
  logic [CH_W-1:0]      tgt_ch;
  logic [STEP_W-1:0]    total;
  logic [STEP_W-1:0]    idx;
  logic                 in_tr;
  logic [DIGIT_W-1:0]   shuf_digit;

  // Sequencer and serial arithmetic
  state_t               state;
  state_t               state_next;
  logic [PROD_W-1:0]    acc;
  logic [STEP_W-1:0]    mult;
  logic [DUTY_BITS-1:0] mcand;
  logic [CNT_W-1:0]     bit_cnt;

  // Pending result list
  logic [CH_W-1:0]      res_ch   [MAX_RES];
  logic [DUTY_BITS-1:0] res_duty [MAX_RES];
  logic [RES_W-1:0]     res_cnt;
  logic [RES_W-1:0]     res_sel;

  // Control terms
  logic                 accept;
  logic                 out_free;
  logic                 active;
  logic                 fade_go;
  logic                 list_go;
  logic                 mul_done;
  logic                 div_done;
  logic                 emit_load;
  logic                 emit_last;
  logic [STEP_W-1:0]    idx_inc;
  logic [DIGIT_W-1:0]   shuf_prev;

  // Divider step terms
  logic [STEP_W:0]      div_r2;
  logic [STEP_W:0]      div_diff;
  logic                 div_ge;
  logic [STEP_W-1:0]    div_rem;
  logic [DUTY_BITS-1:0] div_quo;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_NORMAL;
      bright <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:   mode   <= mode_t'(cfg_data[MODE_W-1:0]);
        REG_BRIGHT: bright <= cfg_data;
      endcase
    end
  end

  // Shared combinational terms.
  assign idx_inc   = idx + STEP_W'(1);
  assign active    = in_tr && (idx < total);
  assign shuf_prev = (shuf_digit == '0) ? DIGIT_W'(NUM_DIGITS - 1)
                                        : shuf_digit - DIGIT_W'(1);

  // One restoring division step: bring down the next dividend bit.
  assign div_r2   = {acc[PROD_W-1:DUTY_BITS], acc[DUTY_BITS-1]};
  assign div_diff = div_r2 - {1'b0, total};
  assign div_ge   = (div_r2 >= {1'b0, total});
  assign div_rem  = div_ge ? div_diff[STEP_W-1:0] : div_r2[STEP_W-1:0];
  assign div_quo  = {acc[DUTY_BITS-2:0], div_ge};

  // Sequencer control outputs; no beat is taken while reset is held.
  always_comb begin
    in_ready  = (state == ST_IDLE) && !rst;
    accept    = in_valid && in_ready;
    out_free  = !out_valid || out_ready;
    fade_go   = accept && (cmd == CMD_TICK) && active && (mode == MODE_FADE)
                && (cur_ch != tgt_ch);
    list_go   = accept && (cmd == CMD_TICK) && active && (mode != MODE_FADE);
    mul_done  = (state == ST_MUL) && (bit_cnt == CNT_LAST);
    div_done  = (state == ST_DIV) && (bit_cnt == CNT_LAST);
    emit_load = (state == ST_EMIT) && out_free;
    emit_last = (res_sel == res_cnt - RES_W'(1));
  end

  // Sequencer next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (fade_go) begin
          state_next = ST_MUL;
        end else if (list_go) begin
          state_next = ST_EMIT;
        end
      end
      ST_MUL: begin
        if (mul_done) state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_load && emit_last) state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Transition state updates on each accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_ch     <= CH_DIGIT_0;
      tgt_ch     <= CH_DIGIT_0;
      total      <= '0;
      idx        <= '0;
      in_tr      <= 1'b0;
      shuf_digit <= '0;
    end else if (accept) begin
      if (cmd == CMD_SET) begin
        total      <= steps;
        idx        <= '0;
        shuf_digit <= '0;
        cur_ch     <= tgt_ch;
        tgt_ch     <= digit_to_channel(digit);
        in_tr      <= 1'b1;
      end else if (active) begin
        // A fade with nothing to fade, or a plain switch, ends the transition.
        if ((mode == MODE_FADE && cur_ch == tgt_ch) || mode == MODE_NORMAL
            || mode == MODE_SPARE) begin
          in_tr <= 1'b0;
        end
        idx        <= idx_inc;
        shuf_digit <= (shuf_digit == DIGIT_W'(NUM_DIGITS - 1)) ? '0
                                                               : shuf_digit + DIGIT_W'(1);
        if (idx_inc == total) cur_ch <= tgt_ch;
      end else begin
        in_tr  <= 1'b0;
        cur_ch <= tgt_ch;
      end
    end
  end

  // Serial arithmetic: shift-and-add multiply, then restoring divide.
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_cnt <= '0;
    end else if (fade_go || mul_done || div_done) begin
      bit_cnt <= '0;
    end else if (state == ST_MUL || state == ST_DIV) begin
      bit_cnt <= bit_cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (fade_go) begin
      acc   <= '0;
      mult  <= idx_inc;
      mcand <= bright;
    end else if (state == ST_MUL) begin
      acc   <= {acc[PROD_W-2:0], 1'b0} + (mcand[DUTY_BITS-1] ? PROD_W'(mult) : '0);
      mcand <= {mcand[DUTY_BITS-2:0], 1'b0};
    end else if (state == ST_DIV) begin
      acc   <= {div_rem, div_quo};
    end
  end

  // Result list: channels are fixed at accept time, fade duties after the divide.
  always_ff @(posedge clk) begin
    if (fade_go) begin
      res_ch[0] <= cur_ch;
      res_ch[1] <= tgt_ch;
      res_cnt   <= RES_W'(2);
    end else if (list_go) begin
      res_ch[0]   <= cur_ch;
      res_duty[0] <= '0;
      if (mode == MODE_SHUFFLE) begin
        res_ch[1]   <= digit_to_channel(shuf_prev);
        res_duty[1] <= '0;
        res_ch[2]   <= (idx_inc < total) ? digit_to_channel(shuf_digit) : tgt_ch;
        res_duty[2] <= bright;
        res_cnt     <= RES_W'(3);
      end else begin
        res_ch[1]   <= tgt_ch;
        res_duty[1] <= bright;
        res_cnt     <= RES_W'(2);
      end
    end else if (div_done) begin
      // The old channel takes the brightness less the ceiling of the new share.
      res_duty[1] <= div_quo;
      res_duty[0] <= bright - div_quo - DUTY_BITS'(div_rem != '0);
    end
  end

  // Output register: one result beat per cycle while the sink keeps up.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      res_sel   <= '0;
    end else begin
      if (fade_go || list_go) begin
        res_sel <= '0;
      end else if (emit_load) begin
        res_sel <= res_sel + RES_W'(1);
      end
      if (emit_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      channel <= res_ch[res_sel];
      duty    <= res_duty[res_sel];
      last    <= emit_last;
    end
  end

endmodule

// ----- rtl/dts_checker.sv -----
// ----------------------------------------------------------------------------
// Digit transition sequencer checker
// Port-level assertions on the sequencer, attached by a bind statement.
// ----------------------------------------------------------------------------
module dts_checker
  import dts_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 cmd,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [CH_W-1:0]      channel,
  input logic [DUTY_BITS-1:0] duty,
  input logic                 last
);

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(channel) && $stable(duty)
                                && $stable(last))
    else $error("result beat changed while stalled");

  // Every written channel belongs to a digit.
  a_channel_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> channel <= CH_W'(NUM_DIGITS - 1))
    else $error("result channel out of range");

  // No new command is taken while a tick still has results to give.
  a_busy_mid_list: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> !in_ready)
    else $error("input taken before the tick's last result");

  // A set command leaves the sequencer ready for the next beat.
  a_set_single_cycle: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && cmd == CMD_SET |=> in_ready)
    else $error("set command held the input side");

endmodule

bind digit_transition_sequencer dts_checker u_dts_checker (.*);
